>>> hdl/acsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI CSI decoder package
// Shared types, character codes, register indexes and the color table of the
// terminal escape-sequence decoder.
// ----------------------------------------------------------------------------
package acsi_pkg;

  localparam int MAX_PARAMS_DEF = 4;
  localparam int PARAM_BITS_DEF = 16;

  localparam int SCR_W       = 13;
  localparam int POS_W       = 16;
  localparam int ARGB_W      = 32;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SCR_W-1:0]  SCREEN_W_RST = 13'd640;
  localparam logic [SCR_W-1:0]  SCREEN_H_RST = 13'd480;
  localparam logic [ARGB_W-1:0] ARGB_WHITE   = 32'hFFFF_FFFF;
  localparam logic [POS_W-1:0]  CELL_W       = 16'd8;
  localparam logic [POS_W-1:0]  CELL_H       = 16'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 2'd1;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_UP     = 8'h41;
  localparam logic [7:0] CH_DOWN   = 8'h42;
  localparam logic [7:0] CH_RIGHT  = 8'h43;
  localparam logic [7:0] CH_LEFT   = 8'h44;
  localparam logic [7:0] CH_CUP    = 8'h48;
  localparam logic [7:0] CH_ERASE  = 8'h4A;
  localparam logic [7:0] CH_SGR    = 8'h6D;

  localparam int SGR_FG_BASE = 30;

  typedef enum logic [1:0] {
    ACT_CONSUMED = 2'd0,
    ACT_PASS     = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_UPDATE   = 2'd3
  } action_t;

  // Decoded byte from the parser to the executor.
  typedef struct packed {
    logic       pass;
    logic       is_final;
    logic [7:0] code;
    logic       cnt_ge1;
    logic       cnt_one;
    logic       cnt_two;
  } cmd_t;

  typedef struct packed {
    action_t             action;
    logic [7:0]          out_byte;
    logic [POS_W-1:0]    cursor_x;
    logic [POS_W-1:0]    cursor_y;
    logic [ARGB_W-1:0]   argb;
  } result_t;

  function automatic logic [ARGB_W-1:0] color_lut(input logic [2:0] idx);
    logic [ARGB_W-1:0] c;
    unique case (idx)
      3'd0: c = 32'hFF00_0000;
      3'd1: c = 32'hFFFF_0000;
      3'd2: c = 32'hFF00_FF00;
      3'd3: c = 32'hFFFF_FF00;
      3'd4: c = 32'hFF00_00FF;
      3'd5: c = 32'hFFFF_00FF;
      3'd6: c = 32'hFF00_FFFF;
      default: c = 32'hFFFF_FFFF;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/acsi_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI CSI parser
// Tracks the escape state and collects the decimal parameters of a control
// sequence, and hands the decoded byte to the executor.
// ----------------------------------------------------------------------------
module acsi_parser
  import acsi_pkg::*;
#(
  parameter int MAX_PARAMS = MAX_PARAMS_DEF,
  parameter int PARAM_BITS = PARAM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            in_byte,
  output cmd_t                  cmd,
  output logic [PARAM_BITS-1:0] p0,
  output logic [PARAM_BITS-1:0] p1,
  output logic [PARAM_BITS-1:0] plast
);

  localparam int CNT_W = $clog2(MAX_PARAMS + 2);
  localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int IDX1  = (MAX_PARAMS >= 2) ? 1 : 0;
  localparam int ACC_W = PARAM_BITS + 4;

  typedef enum logic [1:0] {
    PS_NORMAL,
    PS_ESC,
    PS_CSI
  } pstate_t;

  pstate_t               state, state_next;
  logic [PARAM_BITS-1:0] params [MAX_PARAMS];
  logic [CNT_W-1:0]      count, count_next;
  logic [CNT_W-1:0]      cnt_eff;
  logic [CNT_W-1:0]      k_full;
  logic [IDX_W-1:0]      k;
  logic                  is_digit;
  logic                  clear_all;
  logic                  wr_digit;
  logic [ACC_W-1:0]      acc;
  logic [PARAM_BITS-1:0] acc_sat;

  assign cnt_eff  = (count == '0) ? CNT_W'(1) : count;
  assign k_full   = cnt_eff - CNT_W'(1);
  assign k        = k_full[IDX_W-1:0];
  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);

  assign acc = {params[k], 3'b000} + {2'b00, params[k], 1'b0}
             + ACC_W'(in_byte - CH_ZERO);
  assign acc_sat = (acc > ACC_W'({PARAM_BITS{1'b1}})) ? {PARAM_BITS{1'b1}}
                                                      : acc[PARAM_BITS-1:0];

  assign p0    = params[0];
  assign p1    = params[IDX1];
  assign plast = params[k];

  always_comb begin
    state_next   = state;
    count_next   = count;
    clear_all    = 1'b0;
    wr_digit     = 1'b0;
    cmd          = '0;
    cmd.code     = in_byte;
    cmd.cnt_ge1  = (cnt_eff >= CNT_W'(1));
    cmd.cnt_one  = (cnt_eff == CNT_W'(1));
    cmd.cnt_two  = (MAX_PARAMS >= 2) && (cnt_eff == CNT_W'(2));
    unique case (state)
      PS_ESC: begin
        if (in_byte == CH_LBRACK) begin
          clear_all  = 1'b1;
          state_next = PS_CSI;
        end else begin
          state_next = PS_NORMAL;
        end
      end
      PS_CSI: begin
        count_next = cnt_eff;
        if (is_digit) begin
          wr_digit = 1'b1;
        end else if (in_byte == CH_QUEST) begin
          count_next = cnt_eff;
        end else if (in_byte == CH_SEMI) begin
          if (cnt_eff < CNT_W'(MAX_PARAMS)) begin
            count_next = cnt_eff + CNT_W'(1);
          end
        end else begin
          cmd.is_final = 1'b1;
          clear_all    = 1'b1;
          state_next   = PS_NORMAL;
        end
      end
      default: begin
        if (in_byte == CH_ESC) begin
          state_next = PS_ESC;
        end else begin
          state_next = PS_NORMAL;
          cmd.pass   = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PS_NORMAL;
      count <= '0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        params[i] <= '0;
      end
    end else if (step) begin
      state <= state_next;
      if (clear_all) begin
        count <= '0;
        for (int i = 0; i < MAX_PARAMS; i++) begin
          params[i] <= '0;
        end
      end else begin
        count <= count_next;
        if (wr_digit) begin
          params[k] <= acc_sat;
        end
      end
    end
  end

endmodule

>>> hdl/acsi_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI CSI executor
// Holds the cursor, the text color and the screen size registers, and acts on
// each decoded byte to form the result of the transfer.
// ----------------------------------------------------------------------------
module acsi_exec
  import acsi_pkg::*;
#(
  parameter int PARAM_BITS = PARAM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  cmd_t                  cmd,
  input  logic [PARAM_BITS-1:0] p0,
  input  logic [PARAM_BITS-1:0] p1,
  input  logic [PARAM_BITS-1:0] plast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SCR_W-1:0]      cfg_data,
  output result_t               res
);

  localparam int PLC_W = (PARAM_BITS + 4 > POS_W) ? PARAM_BITS + 4 : POS_W;

  logic [POS_W-1:0]  cur_x, cur_x_next;
  logic [POS_W-1:0]  cur_y, cur_y_next;
  logic [ARGB_W-1:0] color, color_next;
  logic [SCR_W-1:0]  scr_w;
  logic [SCR_W-1:0]  scr_h;
  logic [POS_W:0]    down_sum;
  logic [POS_W:0]    right_sum;
  logic [PARAM_BITS-1:0] erase_p;
  logic [PARAM_BITS-1:0] sgr_off;
  logic              sgr_white;
  action_t           act;

  function automatic logic [POS_W-1:0] place(input logic [PARAM_BITS-1:0] p,
                                             input logic is_row,
                                             input logic [SCR_W-1:0] lim);
    logic [PARAM_BITS-1:0] pm1;
    logic [PLC_W-1:0]      pos;
    logic [SCR_W-1:0]      cell_sz;
    logic [POS_W-1:0]      r;
    pm1     = (p == '0) ? '0 : p - PARAM_BITS'(1);
    pos     = is_row ? (PLC_W'(pm1) << 4) : (PLC_W'(pm1) << 3);
    cell_sz = is_row ? SCR_W'(16) : SCR_W'(8);
    if (pos >= PLC_W'(lim)) begin
      r = (lim >= cell_sz) ? {{(POS_W-SCR_W){1'b0}}, lim - cell_sz} : '0;
    end else begin
      r = pos[POS_W-1:0];
    end
    return r;
  endfunction

  assign down_sum  = {1'b0, cur_y} + {1'b0, CELL_H};
  assign right_sum = {1'b0, cur_x} + {1'b0, CELL_W};
  assign erase_p   = cmd.cnt_ge1 ? p0 : '0;
  assign sgr_off   = plast - PARAM_BITS'(SGR_FG_BASE);
  assign sgr_white = !cmd.cnt_ge1 || (cmd.cnt_one && p0 == '0)
                  || (cmd.cnt_two && p0 == '0 && p1 == '0);

  always_comb begin
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    color_next = color;
    act        = ACT_CONSUMED;
    if (cmd.pass) begin
      act = ACT_PASS;
    end else if (cmd.is_final) begin
      unique case (cmd.code)
        CH_UP: begin
          act = ACT_UPDATE;
          if (cur_y >= CELL_H) begin
            cur_y_next = cur_y - CELL_H;
          end
        end
        CH_DOWN: begin
          act        = ACT_UPDATE;
          cur_y_next = down_sum[POS_W] ? {POS_W{1'b1}} : down_sum[POS_W-1:0];
        end
        CH_RIGHT: begin
          act        = ACT_UPDATE;
          cur_x_next = right_sum[POS_W] ? {POS_W{1'b1}} : right_sum[POS_W-1:0];
        end
        CH_LEFT: begin
          act = ACT_UPDATE;
          if (cur_x >= CELL_W) begin
            cur_x_next = cur_x - CELL_W;
          end
        end
        CH_CUP: begin
          act = ACT_UPDATE;
          if (cmd.cnt_one || cmd.cnt_two) begin
            cur_y_next = place(p0, 1'b1, scr_h);
            cur_x_next = place(cmd.cnt_two ? p1 : PARAM_BITS'(1), 1'b0, scr_w);
          end else begin
            cur_x_next = '0;
            cur_y_next = '0;
          end
        end
        CH_ERASE: begin
          if (erase_p == PARAM_BITS'(0) || erase_p == PARAM_BITS'(2)
              || erase_p == PARAM_BITS'(3)) begin
            act        = ACT_CLEAR;
            cur_x_next = '0;
            cur_y_next = '0;
          end
        end
        CH_SGR: begin
          act = ACT_UPDATE;
          if (sgr_white) begin
            color_next = ARGB_WHITE;
          end else if (plast >= PARAM_BITS'(SGR_FG_BASE)
                       && plast <= PARAM_BITS'(SGR_FG_BASE + 7)) begin
            color_next = color_lut(sgr_off[2:0]);
          end
        end
        default: begin
          act = ACT_CONSUMED;
        end
      endcase
    end
  end

  always_comb begin
    res          = '0;
    res.action   = act;
    res.out_byte = cmd.pass ? cmd.code : 8'h00;
    res.cursor_x = cur_x_next;
    res.cursor_y = cur_y_next;
    res.argb     = color_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0;
      cur_y <= '0;
      color <= ARGB_WHITE;
      scr_w <= SCREEN_W_RST;
      scr_h <= SCREEN_H_RST;
    end else begin
      if (step) begin
        cur_x <= cur_x_next;
        cur_y <= cur_y_next;
        color <= color_next;
      end
      if (cfg_we && cfg_index == CFG_SCREEN_W) begin
        scr_w <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_SCREEN_H) begin
        scr_h <= cfg_data;
      end
    end
  end

endmodule

>>> hdl/ansi_csi_terminal_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI CSI terminal decoder
// Decodes a terminal byte stream with ESC-[ control sequences into print,
// clear and cursor or color actions, with a pixel cursor and an ARGB color.
//
// One byte enters per transfer on the input channel (in_valid, in_ready,
// input_byte). Each byte yields exactly one result transfer on the output
// channel (out_valid, out_ready, action, out_byte, cursor_x_px, cursor_y_px,
// text_argb), in order.
// A byte is first held in the input register; its result is then decoded and
// loaded into the result register when that register can advance, and it is
// valid there until the receiver takes it.
// The throughput is one byte per cycle while the receiver does not stall; the
// cursor, color and parameter registers are updated in that single step.
// When the receiver stalls, the result register holds, the input register
// still takes one more byte, and in_ready then drops until the result is
// taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 sets the screen width and index 1 the screen height.
// Reset clears the parser, homes the cursor, sets the color to white and the
// screen size to 640 by 480 pixels.
// ----------------------------------------------------------------------------
module ansi_csi_terminal_decoder
  import acsi_pkg::*;
#(
  parameter int MAX_PARAMS = MAX_PARAMS_DEF,
  parameter int PARAM_BITS = PARAM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           input_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           action,
  output logic [7:0]           out_byte,
  output logic [POS_W-1:0]     cursor_x_px,
  output logic [POS_W-1:0]     cursor_y_px,
  output logic [ARGB_W-1:0]    text_argb,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCR_W-1:0]     cfg_data
);

  logic                  s1_valid;
  logic [7:0]            s1_byte;
  logic                  advance;
  logic                  step;
  cmd_t                  cmd;
  logic [PARAM_BITS-1:0] p0;
  logic [PARAM_BITS-1:0] p1;
  logic [PARAM_BITS-1:0] plast;
  result_t               res_next;
  result_t               res;

  assign advance   = !out_valid || out_ready;
  assign step      = s1_valid && advance;
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  acsi_parser #(
    .MAX_PARAMS (MAX_PARAMS),
    .PARAM_BITS (PARAM_BITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (s1_byte),
    .cmd     (cmd),
    .p0      (p0),
    .p1      (p1),
    .plast   (plast)
  );

  acsi_exec #(
    .PARAM_BITS (PARAM_BITS)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .cmd       (cmd),
    .p0        (p0),
    .p1        (p1),
    .plast     (plast),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= step;
      end
    end
    if (in_valid && in_ready) begin
      s1_byte <= input_byte;
    end
    if (step) begin
      res <= res_next;
    end
  end

  assign action      = res.action;
  assign out_byte    = res.out_byte;
  assign cursor_x_px = res.cursor_x;
  assign cursor_y_px = res.cursor_y;
  assign text_argb   = res.argb;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the result register is empty");

  a_step_fills_output: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("decoded byte did not reach the result register");

  a_byte_only_on_pass: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.action != ACT_PASS |-> out_byte == 8'h00)
    else $error("output byte set on a result that does not print");

  a_clear_homes: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.action == ACT_CLEAR |-> cursor_x_px == '0 && cursor_y_px == '0)
    else $error("screen clear did not home the cursor");

endmodule

>>> bench/ansi_csi_terminal_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI CSI terminal decoder testbench
// Drives byte streams of plain text, broken escapes and well-formed ESC-[
// sequences through the decoder under random stalls on both channels, and
// checks every result against a directed table or a cycle-free model of the
// parser, the cursor and the text color across several screen sizes.
// ----------------------------------------------------------------------------
module ansi_csi_terminal_decoder_test;
  import acsi_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 60;
  localparam logic [POS_W-1:0] POS_TOP = 16'hFFFF;

  typedef enum logic [1:0] {
    PM_TEXT = 2'd0,
    PM_ESC  = 2'd1,
    PM_CSI  = 2'd2
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] code;
    logic       typed;
    result_t    res;
  } stim_row_t;

  localparam result_t RES_NONE = '{ACT_CONSUMED, 8'h00, 16'd0, 16'd0, 32'h0};

  localparam logic [ARGB_W-1:0] FG_ARGB [8] = '{
    32'hFF00_0000, 32'hFFFF_0000, 32'hFF00_FF00, 32'hFFFF_FF00,
    32'hFF00_00FF, 32'hFFFF_00FF, 32'hFF00_FFFF, 32'hFFFF_FFFF
  };

  localparam logic [7:0] FINALS [7] = '{
    CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, CH_CUP, CH_ERASE, CH_SGR
  };

  localparam stim_row_t DIR_TAB [27] = '{
    '{8'h61, 1'b1, '{ACT_PASS, 8'h61, 16'd0, 16'd0, ARGB_WHITE}},
    '{8'h00, 1'b1, '{ACT_PASS, 8'h00, 16'd0, 16'd0, ARGB_WHITE}},
    '{8'hFF, 1'b1, '{ACT_PASS, 8'hFF, 16'd0, 16'd0, ARGB_WHITE}},
    '{CH_ESC, 1'b1, '{ACT_CONSUMED, 8'h00, 16'd0, 16'd0, ARGB_WHITE}},
    '{8'h78, 1'b1, '{ACT_CONSUMED, 8'h00, 16'd0, 16'd0, ARGB_WHITE}},
    '{CH_ESC, 1'b0, RES_NONE},
    '{CH_LBRACK, 1'b0, RES_NONE},
    '{CH_ZERO + 8'd3, 1'b0, RES_NONE},
    '{CH_ZERO + 8'd1, 1'b0, RES_NONE},
    '{CH_SGR, 1'b1, '{ACT_UPDATE, 8'h00, 16'd0, 16'd0, 32'hFFFF_0000}},
    '{CH_ESC, 1'b0, RES_NONE},
    '{CH_LBRACK, 1'b0, RES_NONE},
    '{CH_ZERO + 8'd7, 1'b0, RES_NONE},
    '{CH_ZERO, 1'b0, RES_NONE},
    '{CH_ZERO, 1'b0, RES_NONE},
    '{CH_ZERO, 1'b0, RES_NONE},
    '{CH_ZERO, 1'b0, RES_NONE},
    '{CH_CUP, 1'b1, '{ACT_UPDATE, 8'h00, 16'd0, 16'd464, 32'hFFFF_0000}},
    '{CH_ESC, 1'b0, RES_NONE},
    '{CH_LBRACK, 1'b0, RES_NONE},
    '{CH_SEMI, 1'b0, RES_NONE},
    '{CH_SEMI, 1'b0, RES_NONE},
    '{CH_SEMI, 1'b0, RES_NONE},
    '{CH_SEMI, 1'b0, RES_NONE},
    '{CH_ZERO + 8'd3, 1'b0, RES_NONE},
    '{CH_ZERO + 8'd2, 1'b0, RES_NONE},
    '{CH_SGR, 1'b1, '{ACT_UPDATE, 8'h00, 16'd0, 16'd464, 32'hFF00_FF00}}
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           input_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           action;
  logic [7:0]           out_byte;
  logic [POS_W-1:0]     cursor_x_px;
  logic [POS_W-1:0]     cursor_y_px;
  logic [ARGB_W-1:0]    text_argb;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SCREEN_W;
  logic [SCR_W-1:0]     cfg_data = '0;

  // Decoder model state.
  parse_mode_t       parse_mode = PM_TEXT;
  logic [15:0]       arg_val [4] = '{16'd0, 16'd0, 16'd0, 16'd0};
  logic [2:0]        arg_cnt = 3'd0;
  logic [POS_W-1:0]  term_x = '0;
  logic [POS_W-1:0]  term_y = '0;
  logic [ARGB_W-1:0] term_argb = ARGB_WHITE;
  logic [SCR_W-1:0]  scr_w = SCREEN_W_RST;
  logic [SCR_W-1:0]  scr_h = SCREEN_H_RST;

  result_t results_due [$];
  int      errors = 0;
  int      bytes_sent = 0;
  int      cycles = 0;
  bit      calm = 1'b0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;

  ansi_csi_terminal_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .input_byte  (input_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .action      (action),
    .out_byte    (out_byte),
    .cursor_x_px (cursor_x_px),
    .cursor_y_px (cursor_y_px),
    .text_argb   (text_argb),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [POS_W-1:0] cell_pos(input logic [15:0] p,
                                               input int unsigned cell_sz,
                                               input logic [SCR_W-1:0] limit);
    int unsigned n;
    int unsigned pos;
    n = (p == 16'd0) ? 1 : int'(p);
    pos = (n - 1) * cell_sz;
    if (pos >= limit) pos = (limit >= cell_sz) ? limit - cell_sz : 0;
    return pos[POS_W-1:0];
  endfunction

  function automatic action_t run_final(input logic [7:0] c);
    action_t     act;
    int unsigned sum;
    int unsigned slot;
    logic [15:0] p1;
    logic [15:0] sel;
    act = ACT_UPDATE;
    case (c)
      CH_UP: begin
        if (term_y >= CELL_H) term_y = term_y - CELL_H;
      end
      CH_DOWN: begin
        sum = int'(term_y) + int'(CELL_H);
        term_y = (sum > 32'hFFFF) ? POS_TOP : sum[15:0];
      end
      CH_RIGHT: begin
        sum = int'(term_x) + int'(CELL_W);
        term_x = (sum > 32'hFFFF) ? POS_TOP : sum[15:0];
      end
      CH_LEFT: begin
        if (term_x >= CELL_W) term_x = term_x - CELL_W;
      end
      CH_CUP: begin
        if (arg_cnt == 3'd1 || arg_cnt == 3'd2) begin
          p1 = (arg_cnt == 3'd2) ? arg_val[1] : 16'd1;
          term_y = cell_pos(arg_val[0], CELL_H, scr_h);
          term_x = cell_pos(p1, CELL_W, scr_w);
        end else begin
          term_x = '0;
          term_y = '0;
        end
      end
      CH_ERASE: begin
        if (arg_val[0] == 16'd0 || arg_val[0] == 16'd2 || arg_val[0] == 16'd3) begin
          term_x = '0;
          term_y = '0;
          act = ACT_CLEAR;
        end else begin
          act = ACT_CONSUMED;
        end
      end
      CH_SGR: begin
        if (arg_cnt == 3'd0 || (arg_cnt == 3'd1 && arg_val[0] == 16'd0) ||
            (arg_cnt == 3'd2 && arg_val[0] == 16'd0 && arg_val[1] == 16'd0)) begin
          term_argb = ARGB_WHITE;
        end else begin
          slot = (arg_cnt > 3'd4) ? 3 : int'(arg_cnt) - 1;
          sel = arg_val[slot];
          if (sel >= SGR_FG_BASE && sel <= SGR_FG_BASE + 7)
            term_argb = FG_ARGB[sel - SGR_FG_BASE];
        end
      end
      default: act = ACT_CONSUMED;
    endcase
    arg_val = '{16'd0, 16'd0, 16'd0, 16'd0};
    arg_cnt = 3'd0;
    parse_mode = PM_TEXT;
    return act;
  endfunction

  function automatic result_t decode_byte(input logic [7:0] c);
    result_t     r;
    int unsigned slot;
    int unsigned acc;
    r = RES_NONE;
    case (parse_mode)
      PM_ESC: begin
        if (c == CH_LBRACK) begin
          arg_val = '{16'd0, 16'd0, 16'd0, 16'd0};
          arg_cnt = 3'd0;
          parse_mode = PM_CSI;
        end else begin
          parse_mode = PM_TEXT;
        end
      end
      PM_CSI: begin
        if (arg_cnt == 3'd0) arg_cnt = 3'd1;
        if (c >= CH_ZERO && c <= CH_NINE) begin
          slot = (arg_cnt > 3'd4) ? 3 : int'(arg_cnt) - 1;
          acc = int'(arg_val[slot]) * 10 + int'(c - CH_ZERO);
          arg_val[slot] = (acc > 32'hFFFF) ? 16'hFFFF : acc[15:0];
        end else if (c == CH_QUEST) begin
        end else if (c == CH_SEMI) begin
          if (arg_cnt < 3'd4) arg_cnt = arg_cnt + 3'd1;
        end else begin
          r.action = run_final(c);
        end
      end
      default: begin
        if (c == CH_ESC) begin
          parse_mode = PM_ESC;
        end else begin
          parse_mode = PM_TEXT;
          r.action = ACT_PASS;
          r.out_byte = c;
        end
      end
    endcase
    r.cursor_x = term_x;
    r.cursor_y = term_y;
    r.argb = term_argb;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input result_t fixed = RES_NONE);
    result_t r;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    input_byte <= b;
    do @(posedge clk); while (!in_ready);
    r = decode_byte(b);
    results_due.push_back(typed ? fixed : r);
    bytes_sent++;
  endtask

  task automatic send_number(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_cmd(input logic [7:0] fin);
    send_byte(CH_ESC);
    send_byte(CH_LBRACK);
    send_byte(fin);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SCREEN_W) scr_w = val;
    else if (idx == CFG_SCREEN_H) scr_h = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_arg();
    int unsigned pick;
    pick = $urandom_range(0, 11);
    if ($urandom_range(0, 19) == 0) send_byte(CH_QUEST);
    case (pick)
      0: ;
      1: send_number(0);
      2, 3, 4: send_number(SGR_FG_BASE + $urandom_range(0, 7));
      5: send_number($urandom_range(0, 9));
      6: send_number($urandom_range(0, 99));
      7: send_number($urandom_range(0, 600));
      8: send_number($urandom_range(0, 65535));
      9: send_number($urandom_range(65536, 999999));
      10: begin
        send_byte(CH_ZERO);
        send_number(SGR_FG_BASE + $urandom_range(0, 7));
      end
      default: send_number($urandom_range(1, 3));
    endcase
  endtask

  task automatic send_csi();
    logic [7:0]  fin;
    int unsigned nargs;
    fin = ($urandom_range(0, 99) < 85) ? FINALS[$urandom_range(0, 6)] : 8'($urandom_range(0, 255));
    nargs = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 6);
    send_byte(CH_ESC);
    send_byte(CH_LBRACK);
    if ($urandom_range(0, 9) == 0) send_byte(CH_QUEST);
    for (int i = 0; i < nargs; i++) begin
      if (i != 0) send_byte(CH_SEMI);
      send_arg();
    end
    send_byte(fin);
  endtask

  task automatic send_unit();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      send_csi();
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      send_byte(CH_ESC);
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(CH_ESC);
      send_byte(CH_LBRACK);
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Runs random traffic; halfway through it can stall the receiver for a long
  // stretch and can let the output side empty before going on, as the flags select.
  task automatic random_burst(input int n, input bit rx_hold, input bit tx_pause);
    int  target;
    bit  mid_done;
    target = bytes_sent + n;
    mid_done = 1'b0;
    while (bytes_sent < target) begin
      if (!mid_done && bytes_sent >= target - n / 2) begin
        mid_done = 1'b1;
        if (rx_hold) hold_req = 1'b1;
        if (tx_pause) drain();
      end
      send_unit();
    end
  endtask

  // Steps the cursor past the far screen corner, then from home against the
  // zero floor.
  task automatic walk_to_limits();
    send_byte(CH_ESC);
    send_byte(CH_LBRACK);
    send_number(999);
    send_byte(CH_SEMI);
    send_number(999);
    send_byte(CH_CUP);
    repeat (2) begin
      send_cmd(CH_DOWN);
      send_cmd(CH_RIGHT);
    end
    send_cmd(CH_CUP);
    repeat (2) begin
      send_cmd(CH_UP);
      send_cmd(CH_LEFT);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result transfer: action %0d byte %02h", action, out_byte);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, action);
          errors++;
        end
        if (out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte);
          errors++;
        end
        if (cursor_x_px !== want.cursor_x) begin
          $error("cursor_x_px: expected %0d, got %0d", want.cursor_x, cursor_x_px);
          errors++;
        end
        if (cursor_y_px !== want.cursor_y) begin
          $error("cursor_y_px: expected %0d, got %0d", want.cursor_y, cursor_y_px);
          errors++;
        end
        if (text_argb !== want.argb) begin
          $error("text_argb: expected %08h, got %08h", want.argb, text_argb);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIR_TAB[i]) send_byte(DIR_TAB[i].code, DIR_TAB[i].typed, DIR_TAB[i].res);
    random_burst(100, 1'b0, 1'b1);

    drain();
    write_reg(CFG_SCREEN_W, 13'd8);
    write_reg(CFG_SCREEN_H, 13'd16);
    random_burst(100, 1'b1, 1'b0);

    drain();
    write_reg(CFG_SCREEN_W, 13'd4096);
    write_reg(CFG_SCREEN_H, 13'd4096);
    random_burst(70, 1'b0, 1'b0);
    walk_to_limits();

    drain();
    write_reg(CFG_SCREEN_W, 13'($urandom_range(8, 4096)));
    write_reg(CFG_SCREEN_H, 13'($urandom_range(16, 4096)));
    calm = 1'b1;
    random_burst(100, 1'b0, 1'b0);
    calm = 1'b0;
    random_burst(40, 1'b1, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
